@@ src/sewm_pkg.sv @@
// Shared types, codes, microcode program and merge logic for the sector EEPROM write merge block.
`default_nettype none

package sewm_pkg;

  localparam int unsigned SECTOR_COUNT_DEFAULT = 1024;

  // Sector index = (address >> 2) mod SECTOR_COUNT, by reciprocal multiply.
  localparam int unsigned SECT_X_W    = 14;
  localparam int unsigned RECIP_SHIFT = 28;

  // Request codes
  localparam logic [2:0] REQ_READ      = 3'd0;
  localparam logic [2:0] REQ_BYTE      = 3'd1;
  localparam logic [2:0] REQ_HALF      = 3'd2;
  localparam logic [2:0] REQ_WORD      = 3'd3;
  localparam logic [2:0] REQ_ERASE_ALL = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_MISALIGNED = 2'd1;
  localparam logic [1:0] ST_NODIV      = 2'd2;
  localparam logic [1:0] ST_WINDOW     = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_DIVIDER   = 2'd0;
  localparam logic [1:0] CFG_WIN_FIRST = 2'd1;
  localparam logic [1:0] CFG_WIN_LAST  = 2'd2;

  localparam logic [15:0] WIN_LAST_RESET = 16'd4095;
  localparam logic [15:0] HALF_ERASED    = 16'hFFFF;
  localparam logic [31:0] SECTOR_ERASED  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] address;
    logic [31:0] data;
  } request_t;

  typedef struct packed {
    logic        ok;
    logic [1:0]  status;
    logic [31:0] read_data;
    logic        erased_blank;
  } result_t;

  // Program steps
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
  localparam logic [STEP_W-1:0] STEP_IDX1     = 4'd1;
  localparam logic [STEP_W-1:0] STEP_IDX2     = 4'd2;
  localparam logic [STEP_W-1:0] STEP_IDX3     = 4'd3;
  localparam logic [STEP_W-1:0] STEP_RD       = 4'd4;
  localparam logic [STEP_W-1:0] STEP_MERGE    = 4'd5;
  localparam logic [STEP_W-1:0] STEP_CHK_BASE = 4'd6;
  localparam logic [STEP_W-1:0] STEP_PROG_HI  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_PROG_LO  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_ERA_CHK  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_ERA_SWP  = 4'd10;
  localparam logic [STEP_W-1:0] STEP_FIN      = 4'd11;
  localparam logic [STEP_W-1:0] STEP_CLEAR    = 4'd12;
  localparam logic [STEP_W-1:0] STEP_CLR_END  = 4'd13;

  // Datapath actions
  localparam int unsigned ACT_W = 4;
  localparam logic [ACT_W-1:0] ACT_NONE      = 4'd0;
  localparam logic [ACT_W-1:0] ACT_READ      = 4'd1;
  localparam logic [ACT_W-1:0] ACT_MERGE     = 4'd2;
  localparam logic [ACT_W-1:0] ACT_CHK_BASE  = 4'd3;
  localparam logic [ACT_W-1:0] ACT_PROG_HI   = 4'd4;
  localparam logic [ACT_W-1:0] ACT_PROG_LO   = 4'd5;
  localparam logic [ACT_W-1:0] ACT_CHK_FIRST = 4'd6;
  localparam logic [ACT_W-1:0] ACT_SWEEP     = 4'd7;
  localparam logic [ACT_W-1:0] ACT_EMIT      = 4'd8;

  // Jump conditions
  localparam int unsigned COND_W = 3;
  localparam logic [COND_W-1:0] COND_NEVER    = 3'd0;
  localparam logic [COND_W-1:0] COND_ALWAYS   = 3'd1;
  localparam logic [COND_W-1:0] COND_NSTART   = 3'd2;
  localparam logic [COND_W-1:0] COND_REJECT   = 3'd3;
  localparam logic [COND_W-1:0] COND_MASS     = 3'd4;
  localparam logic [COND_W-1:0] COND_IS_READ  = 3'd5;
  localparam logic [COND_W-1:0] COND_CHK_FAIL = 3'd6;
  localparam logic [COND_W-1:0] COND_NOT_LAST = 3'd7;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Control store: jump to target when cond holds, else fall through.
  function automatic ucode_t ucode_rom(logic [STEP_W-1:0] step);
    ucode_t uc;
    begin
      unique case (step)
        STEP_IDLE:     uc = '{ACT_NONE,      COND_NSTART,   STEP_IDLE};
        STEP_IDX1:     uc = '{ACT_NONE,      COND_REJECT,   STEP_FIN};
        STEP_IDX2:     uc = '{ACT_NONE,      COND_MASS,     STEP_ERA_CHK};
        STEP_IDX3:     uc = '{ACT_NONE,      COND_NEVER,    STEP_IDLE};
        STEP_RD:       uc = '{ACT_READ,      COND_NEVER,    STEP_IDLE};
        STEP_MERGE:    uc = '{ACT_MERGE,     COND_IS_READ,  STEP_FIN};
        STEP_CHK_BASE: uc = '{ACT_CHK_BASE,  COND_CHK_FAIL, STEP_FIN};
        STEP_PROG_HI:  uc = '{ACT_PROG_HI,   COND_CHK_FAIL, STEP_FIN};
        STEP_PROG_LO:  uc = '{ACT_PROG_LO,   COND_ALWAYS,   STEP_FIN};
        STEP_ERA_CHK:  uc = '{ACT_CHK_FIRST, COND_CHK_FAIL, STEP_FIN};
        STEP_ERA_SWP:  uc = '{ACT_SWEEP,     COND_NOT_LAST, STEP_ERA_SWP};
        STEP_FIN:      uc = '{ACT_EMIT,      COND_ALWAYS,   STEP_IDLE};
        STEP_CLEAR:    uc = '{ACT_SWEEP,     COND_NOT_LAST, STEP_CLEAR};
        STEP_CLR_END:  uc = '{ACT_NONE,      COND_ALWAYS,   STEP_IDLE};
        default:       uc = '{ACT_NONE,      COND_ALWAYS,   STEP_IDLE};
      endcase
      return uc;
    end
  endfunction

  // New sector image for a write request; a read returns the sector as is.
  function automatic logic [31:0] merge_sector(logic [2:0] req_type, logic [1:0] offset,
                                               logic [31:0] wdata, logic [31:0] cur);
    logic [31:0] m;
    begin
      m = cur;
      unique case (req_type)
        REQ_BYTE: begin
          unique case (offset)
            2'd0: m[31:24] = wdata[7:0];
            2'd1: m[23:16] = wdata[7:0];
            2'd2: m[15:8]  = wdata[7:0];
            2'd3: m[7:0]   = wdata[7:0];
          endcase
        end
        REQ_HALF: begin
          if (offset[1]) begin
            m[15:0] = wdata[15:0];
          end else begin
            m[31:16] = wdata[15:0];
          end
        end
        REQ_WORD: m = wdata;
        default:  m = cur;
      endcase
      return m;
    end
  endfunction

endpackage

`default_nettype wire

@@ src/sewm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module sewm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ src/sector_eeprom_write_merge.sv @@
// Top level: microcoded sector EEPROM controller with read-merge-rewrite of 4-byte sectors.
// A refused or unknown request skips to the final step; a failing check ends early.
// Throughput: one request at a time, set by the microcode walking one step per clock;
//   start is taken again in the cycle the result shows. The receiver cannot stall.
// Reset: synchronous; afterwards a clearing pass writes all ones into every sector
//   with busy high. Configuration writes are taken at any time.
`default_nettype none

module sector_eeprom_write_merge
  import sewm_pkg::*;
#(
  parameter int unsigned SECTOR_COUNT = SECTOR_COUNT_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        start,
  output logic             busy,
  input  wire request_t    request,
  // result channel
  output logic             result_valid,
  output result_t          result,
  // configuration write port
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int unsigned IDX_W = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;
  localparam int unsigned PROD_W = SECT_X_W + RECIP_SHIFT + 1;
  localparam logic [RECIP_SHIFT:0] RECIP = (RECIP_SHIFT + 1)'((2 ** RECIP_SHIFT) / SECTOR_COUNT);
  localparam logic [15:0] COUNT = 16'(SECTOR_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SECTOR_COUNT - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic        divider_loaded;
  logic [15:0] window_first_byte;
  logic [15:0] window_last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      divider_loaded    <= 1'b0;
      window_first_byte <= '0;
      window_last_byte  <= WIN_LAST_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DIVIDER:   divider_loaded    <= cfg_data[0];
        CFG_WIN_FIRST: window_first_byte <= cfg_data;
        CFG_WIN_LAST:  window_last_byte  <= cfg_data;
        default:       ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: step counter + control store
  // ---------------------------------------------------------------------------
  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  ucode_t            uc;
  logic              cond_hit;
  logic              accept;

  assign uc     = ucode_rom(pc);
  assign busy   = (pc != STEP_IDLE);
  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // Latched request
  // ---------------------------------------------------------------------------
  logic [2:0]  req_type;
  logic [15:0] address;
  logic [31:0] data;
  logic [1:0]  status;
  logic [31:0] cur;

  logic        known;
  logic        misaligned;
  logic [15:0] base;

  assign known      = (req_type <= REQ_ERASE_ALL);
  assign misaligned = ((req_type == REQ_HALF) && address[0]) ||
                      ((req_type == REQ_WORD) && (address[1:0] != 2'b00));
  assign base       = {address[15:2], 2'b00};

  // Step check: divider first, then window on the step's address.
  logic [15:0] chk_addr;
  logic [1:0]  chk_st;

  always_comb begin
    unique case (uc.act)
      ACT_PROG_HI:   chk_addr = base | 16'd2;
      ACT_CHK_FIRST: chk_addr = window_first_byte;
      default:       chk_addr = base;
    endcase
    if (!divider_loaded) begin
      chk_st = ST_NODIV;
    end else if ((chk_addr < window_first_byte) || (chk_addr > window_last_byte)) begin
      chk_st = ST_WINDOW;
    end else begin
      chk_st = ST_OK;
    end
  end

  // Sweep counter for mass erase and the post-reset clear
  logic [IDX_W-1:0] sweep_cnt;
  logic             sweep_last;

  assign sweep_last = (sweep_cnt == LAST_IDX);

  always_comb begin
    unique case (uc.cond)
      COND_NEVER:    cond_hit = 1'b0;
      COND_ALWAYS:   cond_hit = 1'b1;
      COND_NSTART:   cond_hit = !start;
      COND_REJECT:   cond_hit = !known || misaligned;
      COND_MASS:     cond_hit = (req_type == REQ_ERASE_ALL);
      COND_IS_READ:  cond_hit = (req_type == REQ_READ);
      COND_CHK_FAIL: cond_hit = (chk_st != ST_OK);
      COND_NOT_LAST: cond_hit = !sweep_last;
      default:       cond_hit = 1'b0;
    endcase
    pc_next = cond_hit ? uc.target : pc + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_CLEAR;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (uc.act == ACT_SWEEP) begin
      sweep_cnt <= sweep_last ? '0 : sweep_cnt + IDX_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Sector index pipeline: (address >> 2) mod SECTOR_COUNT.
  // q' = floor(x * RECIP / 2^SHIFT) is q or q-1, so one conditional subtract fixes it.
  // Registered through sect_prod, sect_rem and sect_idx during steps IDX1..IDX3.
  // ---------------------------------------------------------------------------
  logic [SECT_X_W-1:0] sect_x;
  logic [PROD_W-1:0]   sect_prod;
  logic [SECT_X_W-1:0] sect_q;
  logic [28:0]         sect_qn;
  logic [15:0]         sect_rem;
  logic [IDX_W-1:0]    sect_idx;

  assign sect_x  = address[15:2];
  assign sect_q  = sect_prod[RECIP_SHIFT +: SECT_X_W];
  assign sect_qn = 29'(sect_q) * 29'(COUNT);

  always_ff @(posedge clk) begin
    sect_prod <= PROD_W'(sect_x) * PROD_W'(RECIP);
    sect_rem  <= 16'(29'(sect_x) - sect_qn);
    sect_idx  <= (sect_rem >= COUNT) ? IDX_W'(sect_rem - COUNT) : IDX_W'(sect_rem);
  end

  // ---------------------------------------------------------------------------
  // Sector store
  // ---------------------------------------------------------------------------
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [31:0]      ram_wdata;
  logic             ram_re;
  logic [31:0]      ram_rdata;

  // Program high is erase plus high-word program: the low half stays erased
  // unless the low-word program also passes.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sect_idx;
    ram_wdata = cur;
    unique case (uc.act)
      ACT_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_cnt;
        ram_wdata = SECTOR_ERASED;
      end
      ACT_PROG_HI: begin
        ram_we    = (chk_st == ST_OK) || (chk_st == ST_WINDOW);
        ram_wdata = {cur[31:16], HALF_ERASED};
      end
      ACT_PROG_LO: begin
        ram_we = 1'b1;
      end
      default: ;
    endcase
  end

  assign ram_re = (uc.act == ACT_READ);

  sewm_ram #(
    .WIDTH (32),
    .DEPTH (SECTOR_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (sect_idx),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Request datapath
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      req_type <= request.req_type;
      address  <= request.address;
      data     <= request.data;
    end
    if (accept) begin
      status <= ((request.req_type == REQ_HALF) && request.address[0]) ||
                ((request.req_type == REQ_WORD) && (request.address[1:0] != 2'b00))
                ? ST_MISALIGNED : ST_OK;
    end else if ((uc.act == ACT_CHK_BASE) || (uc.act == ACT_PROG_HI) ||
                 (uc.act == ACT_CHK_FIRST)) begin
      status <= chk_st;
    end
    if (uc.act == ACT_MERGE) begin
      cur <= merge_sector(req_type, address[1:0], data, ram_rdata);
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (uc.act == ACT_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (uc.act == ACT_EMIT) begin
      result.ok           <= known && (status == ST_OK);
      result.status       <= status;
      result.read_data    <= (req_type == REQ_READ) ? cur : '0;
      result.erased_blank <= (req_type == REQ_ERASE_ALL) && (status == ST_OK);
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(pc) == STEP_FIN)
    else $error("result strobe without final step");

  a_ok_status: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.ok |-> result.status == ST_OK)
    else $error("ok with failing status");

  a_blank_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.erased_blank |-> result.ok && result.read_data == '0)
    else $error("erase verify flag without success");

  a_sweep_idle: assert property (@(posedge clk) disable iff (rst)
    (pc == STEP_IDLE) |-> sweep_cnt == '0)
    else $error("sweep counter not rewound");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> busy && !result_valid)
    else $error("store written outside a request");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the sector EEPROM write merge controller.
`timescale 1ns / 100ps

module testbench
  import sewm_pkg::*;
();

  localparam int unsigned SECTORS     = SECTOR_COUNT_DEFAULT;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SEGMENTS    = 14;
  localparam int unsigned SEG_ITEMS   = 125;

  // One line of the directed part: either a register write or a request,
  // with a typed-in result where it is obvious.
  typedef struct {
    bit          is_cfg;
    logic [1:0]  cfg_idx;
    logic [15:0] cfg_val;
    request_t    rq;
    bit          known;
    result_t     want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  request_t    request;
  logic        result_valid;
  result_t     result;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // Mirror of the controller: sector contents and the three registers.
  logic [31:0] sector_mirror [SECTORS];
  logic        div_on;
  logic [15:0] win_lo;
  logic [15:0] win_hi;

  result_t     pending_results [$];
  result_t     oldest;
  dir_row_t    dir_rows [$];

  int unsigned sender_idle_pct;
  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned requests_sent;
  int unsigned erase_alls;
  int unsigned settings_used;
  int unsigned cycle_count;

  sector_eeprom_write_merge i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Mirror of the controller's behavior
  // ---------------------------------------------------------------------

  // Gate for one command step: divider first, then the address window.
  function automatic logic [1:0] step_status(logic [15:0] a);
    if (!div_on) return ST_NODIV;
    if (a < win_lo || a > win_hi) return ST_WINDOW;
    return ST_OK;
  endfunction

  // Sector erase, then program high word at base and low word at base + 2.
  // Each step is gated separately, so a late failure leaves partial state.
  function automatic logic [1:0] rewrite_sector(logic [15:0] base, logic [31:0] img);
    logic [1:0]  st;
    logic [15:0] lo_addr;
    int unsigned idx;
    idx     = (base >> 2) % SECTORS;
    lo_addr = base + 16'd2;
    st = step_status(base);
    if (st != ST_OK) return st;
    sector_mirror[idx] = SECTOR_ERASED;
    st = step_status(base);
    if (st != ST_OK) return st;
    sector_mirror[idx][31:16] = img[31:16];
    st = step_status(lo_addr);
    if (st != ST_OK) return st;
    sector_mirror[(lo_addr >> 2) % SECTORS][15:0] = img[15:0];
    return ST_OK;
  endfunction

  // Expected result of one request; updates the mirror as a side effect.
  function automatic result_t predict_result(request_t rq);
    result_t     r;
    logic [31:0] img;
    logic [15:0] base;
    int unsigned idx;
    r    = '0;
    idx  = (rq.address >> 2) % SECTORS;
    base = {rq.address[15:2], 2'b00};
    img  = sector_mirror[idx];
    case (rq.req_type)
      REQ_READ: begin
        r.read_data = img;
        r.ok        = 1'b1;
      end
      REQ_BYTE: begin
        // lower byte address is the more significant byte
        img[8 * (3 - rq.address[1:0]) +: 8] = rq.data[7:0];
        r.status = rewrite_sector(base, img);
        r.ok     = (r.status == ST_OK);
      end
      REQ_HALF: begin
        if (rq.address[0]) begin
          r.status = ST_MISALIGNED;
        end else begin
          if (rq.address[1]) img[15:0] = rq.data[15:0];
          else img[31:16] = rq.data[15:0];
          r.status = rewrite_sector(base, img);
          r.ok     = (r.status == ST_OK);
        end
      end
      REQ_WORD: begin
        if (rq.address[1:0] != 2'b00) begin
          r.status = ST_MISALIGNED;
        end else begin
          r.status = rewrite_sector(rq.address, rq.data);
          r.ok     = (r.status == ST_OK);
        end
      end
      REQ_ERASE_ALL: begin
        // mass erase and erase verify are both gated on the window start
        r.status = step_status(win_lo);
        if (r.status == ST_OK) begin
          for (int i = 0; i < SECTORS; i++) sector_mirror[i] = SECTOR_ERASED;
          r.ok           = 1'b1;
          r.erased_blank = 1'b1;
        end
      end
      default: ;  // unknown request: no effect, all-zero result
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Drivers (all called on a falling edge, return on a falling edge)
  // ---------------------------------------------------------------------

  // Register write, then cfg_write is dropped and the task waits again, so
  // back-to-back calls never assign cfg_write twice in one step.
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_DIVIDER:   div_on = val[0];
      CFG_WIN_FIRST: win_lo = val;
      CFG_WIN_LAST:  win_hi = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Present one request and hold it until the controller takes it.
  // start is left high so the next request can follow back to back.
  task automatic send_request(request_t rq, bit known, result_t typed);
    result_t predicted;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    request <= rq;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    // taken at this edge: predict now, in request order
    predicted = predict_result(rq);
    pending_results.push_back(known ? typed : predicted);
    requests_sent++;
    if (rq.req_type == REQ_ERASE_ALL) erase_alls++;
    @(negedge clk);
  endtask

  // Stop issuing and wait for every outstanding result.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_settings(logic dv, logic [15:0] lo, logic [15:0] hi);
    write_reg(CFG_DIVIDER, {15'd0, dv});
    write_reg(CFG_WIN_FIRST, lo);
    write_reg(CFG_WIN_LAST, hi);
    settings_used++;
  endtask

  // Register setting for one random segment; mostly a window over the
  // hot addresses, with extremes, inverted windows and divider off mixed in.
  task automatic random_settings();
    int unsigned mode;
    logic [15:0] lo;
    logic [15:0] hi;
    mode = $urandom_range(0, 19);
    if (mode < 7) begin
      write_settings(1'b1, 16'h0000, 16'hFFFF);
    end else if (mode < 11) begin
      write_settings(1'b1, 16'h0000, WIN_LAST_RESET);
    end else if (mode < 15) begin
      lo = 16'($urandom_range(0, 16) * 4);
      hi = 16'($urandom_range(64, 65535));
      write_settings(1'b1, lo, hi);
    end else if (mode < 17) begin
      // narrow window so edge steps fail partway through a rewrite
      lo = 16'($urandom_range(0, 20) * 4);
      hi = lo + 16'($urandom_range(0, 40));
      write_settings(1'b1, lo, hi);
    end else if (mode < 18) begin
      lo = 16'($urandom_range(64, 65535)) & 16'hFFFC;
      hi = 16'($urandom_range(0, lo - 1));
      write_settings(1'b1, lo, hi);
    end else if (mode < 19) begin
      write_settings(1'b0, 16'h0000, 16'hFFFF);
    end else begin
      lo = 16'($urandom);
      hi = 16'($urandom);
      write_settings(1'($urandom_range(0, 1)), lo, hi);
    end
  endtask

  // Random request: reads and writes on a small hot set of sectors, so
  // merges land on data written earlier, plus window edges, aliases and noise.
  function automatic request_t random_request();
    request_t    rq;
    int unsigned pick;
    int unsigned apick;
    logic [15:0] off;
    logic [3:0]  hi4;
    logic [11:0] lo12;
    pick  = $urandom_range(0, 199);
    apick = $urandom_range(0, 99);
    off   = 16'($urandom_range(0, 8));
    hi4   = 4'($urandom_range(0, 15));
    lo12  = 12'($urandom_range(0, 95));
    if (pick < 50)       rq.req_type = REQ_READ;
    else if (pick < 90)  rq.req_type = REQ_BYTE;
    else if (pick < 130) rq.req_type = REQ_HALF;
    else if (pick < 175) rq.req_type = REQ_WORD;
    else if (pick < 178) rq.req_type = REQ_ERASE_ALL;
    else if (pick < 188) rq.req_type = 3'($urandom_range(5, 7));
    else                 rq.req_type = 3'($urandom_range(0, 7));
    if (apick < 55)      rq.address = 16'($urandom_range(0, 95));
    else if (apick < 70) rq.address = (apick[0] ? win_lo : win_hi) + off - 16'd4;
    else if (apick < 80) rq.address = {hi4, lo12};  // aliases of the hot sectors
    else                 rq.address = 16'($urandom);
    // mostly well-formed alignment for halfword and word writes
    if ($urandom_range(0, 4) != 0) begin
      if (rq.req_type == REQ_HALF) rq.address[0] = 1'b0;
      if (rq.req_type == REQ_WORD) rq.address[1:0] = 2'b00;
    end
    rq.data = $urandom;
    return rq;
  endfunction

  // ---------------------------------------------------------------------
  // Directed rows
  // ---------------------------------------------------------------------

  function automatic dir_row_t cfg_row(logic [1:0] idx, logic [15:0] val);
    dir_row_t r;
    r = '{1'b1, idx, val, '0, 1'b0, '0};
    return r;
  endfunction

  function automatic dir_row_t req_row(logic [2:0] t, logic [15:0] a, logic [31:0] d);
    dir_row_t r;
    r = '{1'b0, CFG_DIVIDER, 16'd0, request_t'{t, a, d}, 1'b0, '0};
    return r;
  endfunction

  function automatic dir_row_t chk_row(logic [2:0] t, logic [15:0] a, logic [31:0] d,
                                       logic ok, logic [1:0] st, logic [31:0] rd,
                                       logic blank);
    dir_row_t r;
    r = '{1'b0, CFG_DIVIDER, 16'd0, request_t'{t, a, d}, 1'b1,
          result_t'{ok, st, rd, blank}};
    return r;
  endfunction

  task automatic build_directed();
    // out of reset: divider off, window 0..4095, store erased
    dir_rows.push_back(chk_row(REQ_READ, 16'h0000, 32'h0, 1'b1, ST_OK, SECTOR_ERASED, 1'b0));
    dir_rows.push_back(chk_row(REQ_BYTE, 16'h0000, 32'h5A, 1'b0, ST_NODIV, 32'h0, 1'b0));
    // divider check wins over the window check
    dir_rows.push_back(chk_row(REQ_BYTE, 16'hFFFF, 32'hA5, 1'b0, ST_NODIV, 32'h0, 1'b0));
    // alignment is checked before anything else
    dir_rows.push_back(chk_row(REQ_HALF, 16'h0001, 32'h0, 1'b0, ST_MISALIGNED, 32'h0, 1'b0));
    dir_rows.push_back(chk_row(REQ_WORD, 16'h0002, 32'h0, 1'b0, ST_MISALIGNED, 32'h0, 1'b0));
    dir_rows.push_back(chk_row(REQ_ERASE_ALL, 16'h0, 32'h0, 1'b0, ST_NODIV, 32'h0, 1'b0));
    // unknown request type
    dir_rows.push_back(chk_row(3'd7, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, ST_OK, 32'h0, 1'b0));
    dir_rows.push_back(cfg_row(CFG_DIVIDER, 16'd1));
    dir_rows.push_back(chk_row(REQ_WORD, 16'h0000, 32'hDEAD_BEEF, 1'b1, ST_OK, 32'h0, 1'b0));
    dir_rows.push_back(chk_row(REQ_READ, 16'h0002, 32'h0, 1'b1, ST_OK, 32'hDEAD_BEEF, 1'b0));
    // byte and halfword merges into the same sector
    dir_rows.push_back(req_row(REQ_BYTE, 16'h0003, 32'hFFFF_FFA5));
    dir_rows.push_back(req_row(REQ_HALF, 16'h0002, 32'h0000_1234));
    dir_rows.push_back(req_row(REQ_HALF, 16'h0000, 32'hFFFF_5678));
    dir_rows.push_back(req_row(REQ_READ, 16'h0000, 32'h0));
    // last sector inside the reset window, then the first one past it
    dir_rows.push_back(chk_row(REQ_WORD, 16'h0FFC, 32'hFFFF_FFFF, 1'b1, ST_OK, 32'h0, 1'b0));
    dir_rows.push_back(chk_row(REQ_WORD, 16'h1000, 32'h0, 1'b0, ST_WINDOW, 32'h0, 1'b0));
    // top address wraps onto the last sector
    dir_rows.push_back(req_row(REQ_READ, 16'hFFFC, 32'h0));
    // window ends mid-sector: low-word program fails, low word left erased
    dir_rows.push_back(cfg_row(CFG_WIN_LAST, 16'h0FFD));
    dir_rows.push_back(req_row(REQ_WORD, 16'h0FFC, 32'h1111_2222));
    dir_rows.push_back(chk_row(REQ_READ, 16'h0FFE, 32'h0, 1'b1, ST_OK, 32'h1111_FFFF, 1'b0));
    dir_rows.push_back(req_row(REQ_HALF, 16'h0FFE, 32'h0000_ABCD));
    // erase step below the window leaves the sector alone
    dir_rows.push_back(cfg_row(CFG_WIN_FIRST, 16'h0008));
    dir_rows.push_back(req_row(REQ_BYTE, 16'h0004, 32'h0000_0077));
    dir_rows.push_back(chk_row(REQ_ERASE_ALL, 16'h0, 32'h0, 1'b1, ST_OK, 32'h0, 1'b1));
    dir_rows.push_back(chk_row(REQ_READ, 16'h0000, 32'h0, 1'b1, ST_OK, SECTOR_ERASED, 1'b0));
    // inverted window at the extremes: nothing is inside
    dir_rows.push_back(cfg_row(CFG_WIN_FIRST, 16'hFFFF));
    dir_rows.push_back(cfg_row(CFG_WIN_LAST, 16'h0000));
    dir_rows.push_back(chk_row(REQ_ERASE_ALL, 16'h0, 32'h0, 1'b0, ST_WINDOW, 32'h0, 1'b0));
    dir_rows.push_back(chk_row(REQ_BYTE, 16'h0000, 32'h0, 1'b0, ST_WINDOW, 32'h0, 1'b0));
    // full window: write the top sector and read it back through its alias
    dir_rows.push_back(cfg_row(CFG_WIN_FIRST, 16'h0000));
    dir_rows.push_back(cfg_row(CFG_WIN_LAST, 16'hFFFF));
    dir_rows.push_back(req_row(REQ_WORD, 16'hFFFC, 32'h0000_0000));
    dir_rows.push_back(req_row(REQ_READ, 16'h0FFC, 32'h0));
  endtask

  // ---------------------------------------------------------------------
  // Result checker: every strobe is matched against the oldest prediction
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("ERROR: result with no request outstanding: ok=%0b st=%0d rd=%h blank=%0b",
                   result.ok, result.status, result.read_data, result.erased_blank);
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        results_checked++;
        if (result.ok !== oldest.ok || result.status !== oldest.status ||
            result.read_data !== oldest.read_data ||
            result.erased_blank !== oldest.erased_blank) begin
          if (mismatches < 10)
            $display("ERROR: #%0d exp ok=%0b st=%0d rd=%h bl=%0b, got ok=%0b st=%0d rd=%h bl=%0b",
                     results_checked, oldest.ok, oldest.status, oldest.read_data,
                     oldest.erased_blank, result.ok, result.status, result.read_data,
                     result.erased_blank);
          mismatches++;
        end
      end
    end
  end

  // Hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    request         = '0;
    cfg_write       = 1'b0;
    cfg_index       = CFG_DIVIDER;
    cfg_data        = 16'd0;
    div_on          = 1'b0;
    win_lo          = 16'h0000;
    win_hi          = WIN_LAST_RESET;
    sender_idle_pct = 19;
    mismatches      = 0;
    results_checked = 0;
    requests_sent   = 0;
    erase_alls      = 0;
    settings_used   = 0;
    cycle_count     = 0;
    for (int i = 0; i < SECTORS; i++) sector_mirror[i] = SECTOR_ERASED;
    build_directed();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // clearing pass after reset keeps busy high
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    @(negedge clk);

    // directed part; register rows wait for the controller to go quiet
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain_results();
        write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
      end else begin
        send_request(dir_rows[i].rq, dir_rows[i].known, dir_rows[i].want);
      end
    end

    // random part: a fresh register setting per segment; sender idles
    // 19%, then 46%, then not at all
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 5)       sender_idle_pct = 19;
      else if (seg < 10) sender_idle_pct = 46;
      else               sender_idle_pct = 0;
      drain_results();
      random_settings();
      for (int n = 0; n < SEG_ITEMS; n++) send_request(random_request(), 1'b0, '0);
    end

    drain_results();
    // quiet period long enough for a stray erase-all result to show up
    repeat (SECTORS + 8) @(negedge clk);

    $display("Ran %0d requests (%0d erase-all) under %0d register settings; %0d checked.",
             requests_sent, erase_alls, settings_used, results_checked);
    $display("Mismatches: %0d, results still outstanding: %0d",
             mismatches, pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/sewm_pkg.sv
src/sewm_ram.sv
src/sector_eeprom_write_merge.sv
tb/testbench.sv
